// ----- rtl/core/stc_pkg.sv -----
// Shared types and constants for the scope trigger capture block.
package stc_pkg;

  // Samples in one capture frame.
  localparam int unsigned CAPTURE_LENGTH = 1024;
  localparam int unsigned POS_W = $clog2(CAPTURE_LENGTH);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(CAPTURE_LENGTH - 1);

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned INDEX_W = 10;
  localparam int unsigned REG_W = 24;
  localparam int unsigned CNT_W = REG_W + 1;
  localparam int unsigned WAKE_W = 2;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [WAKE_W-1:0] WAKE_FULL = WAKE_W'(2);

  // Item commands.
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  // Result kinds.
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_BLANK = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_TIMEOUT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF_SAMPLES = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_POLYPHONIC = CFG_IDX_W'(2);

  localparam logic [REG_W-1:0] TIMEOUT_RESET = REG_W'(16000);
  localparam logic [REG_W-1:0] HOLDOFF_RESET = REG_W'(4800);

  typedef struct packed {
    logic                       kind;
    logic [INDEX_W-1:0]         capture_index;
    logic signed [SAMPLE_W-1:0] captured_a;
    logic signed [SAMPLE_W-1:0] captured_b;
    logic                       a_present;
    logic                       b_present;
    logic                       last;
  } result_t;

endpackage

// ----- rtl/core/scope_trigger_capture.sv -----
// Two-channel scope capture sequencer with rising-edge trigger and holdoff.
//
//   channel   handshake               payload
//   item      item_valid/item_stall   command, sample_a/b, trigger_sample, flags
//   result    result_valid/           kind, capture_index, captured_a/b,
//             result_stall            a_present, b_present, last
//   config    cfg_write               cfg_index, cfg_data
//
// One item per cycle unless item_stall: the sequencer state updates in the cycle
// an item is accepted; its result, if any, is registered in the output stage.
// A two-entry output stage (result register plus skid register) lets items
// flow while a result waits; item_stall rises only when both are full.
// Reset (rst, synchronous) restores the register defaults and the capturing
// mode with empty wake counts; no clearing pass is needed.
module scope_trigger_capture (
  input  logic                               clk,
  input  logic                               rst,
  // item channel
  input  logic                               item_valid,
  output logic                               item_stall,
  input  logic                               command,
  input  logic signed [stc_pkg::SAMPLE_W-1:0] sample_a,
  input  logic signed [stc_pkg::SAMPLE_W-1:0] sample_b,
  input  logic signed [stc_pkg::SAMPLE_W-1:0] trigger_sample,
  input  logic                               a_streaming,
  input  logic                               b_streaming,
  input  logic                               trigger_streaming,
  input  logic                               a_updated,
  input  logic                               b_updated,
  input  logic                               voice_updated,
  input  logic                               voice_active,
  // result channel
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic                               kind,
  output logic [stc_pkg::INDEX_W-1:0]        capture_index,
  output logic signed [stc_pkg::SAMPLE_W-1:0] captured_a,
  output logic signed [stc_pkg::SAMPLE_W-1:0] captured_b,
  output logic                               a_present,
  output logic                               b_present,
  output logic                               last,
  // configuration
  input  logic                               cfg_write,
  input  logic [stc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [stc_pkg::REG_W-1:0]          cfg_data
);

  typedef enum logic [2:0] {
    MODE_CAPTURING,
    MODE_ARM,
    MODE_FIRE,
    MODE_HOLDOFF,
    MODE_SLEEP
  } mode_t;

  // configuration registers
  logic [stc_pkg::REG_W-1:0] trigger_timeout;
  logic [stc_pkg::REG_W-1:0] holdoff_samples;
  logic                      polyphonic;

  // sequencer state
  mode_t                              mode, mode_next;
  logic [stc_pkg::POS_W-1:0]          pos, pos_next;
  logic signed [stc_pkg::CNT_W-1:0]   cnt, cnt_next;
  logic [stc_pkg::WAKE_W-1:0]         wake_a, wake_a_next;
  logic [stc_pkg::WAKE_W-1:0]         wake_b, wake_b_next;

  // output stage
  stc_pkg::result_t out_r, skid_r, res;
  logic             skid_valid;
  logic             res_hit;

  logic                             item_accept;
  logic                             result_take;
  logic signed [stc_pkg::CNT_W-1:0] cnt_dec;
  logic                             trig_high;
  logic                             cap_en;
  logic [stc_pkg::POS_W-1:0]        cap_pos;
  logic [31:0]                      cap_pos_wide;
  logic                             pa, pb;

  assign item_stall  = skid_valid;
  assign item_accept = item_valid && !skid_valid;
  assign result_take = result_valid && !result_stall;
  assign cnt_dec     = cnt - stc_pkg::CNT_W'(1);
  assign trig_high   = trigger_sample > 16'sd0;
  assign cap_pos_wide = 32'(cap_pos);

  always_comb begin
    mode_next   = mode;
    pos_next    = pos;
    cnt_next    = cnt;
    wake_a_next = wake_a;
    wake_b_next = wake_b;
    cap_en      = 1'b0;
    cap_pos     = pos;
    res_hit     = 1'b0;
    res         = '0;
    pa          = wake_a != '0;
    pb          = wake_b != '0;

    if (item_accept) begin
      if (command == stc_pkg::CMD_UPDATE) begin
        if (a_updated) wake_a_next = stc_pkg::WAKE_FULL;
        if (b_updated) wake_b_next = stc_pkg::WAKE_FULL;
        if (mode == MODE_SLEEP) mode_next = MODE_CAPTURING;
        // voice mute wins over the wake-up
        if (voice_updated && !voice_active && polyphonic) begin
          res_hit   = 1'b1;
          res.kind  = stc_pkg::KIND_BLANK;
          mode_next = MODE_SLEEP;
        end
      end else begin
        case (mode)
          MODE_CAPTURING: begin
            cap_en = 1'b1;
          end
          MODE_ARM: begin
            cnt_next = cnt_dec;
            if (!trig_high) begin
              pos_next  = '0;
              mode_next = cnt_dec[stc_pkg::CNT_W-1] ? MODE_CAPTURING : MODE_FIRE;
            end else if (cnt_dec[stc_pkg::CNT_W-1]) begin
              mode_next = MODE_FIRE;
            end
          end
          MODE_FIRE: begin
            if (trig_high) begin
              cap_en  = 1'b1;
              cap_pos = '0;
            end else begin
              cnt_next = cnt_dec;
              if (cnt_dec[stc_pkg::CNT_W-1]) begin
                pos_next  = '0;
                mode_next = MODE_CAPTURING;
              end
            end
          end
          MODE_HOLDOFF: begin
            cnt_next = cnt_dec;
            if (cnt_dec[stc_pkg::CNT_W-1]) begin
              cnt_next  = $signed({1'b0, trigger_timeout});
              mode_next = MODE_ARM;
            end
          end
          default: begin
          end
        endcase
      end

      if (cap_en) begin
        mode_next = MODE_CAPTURING;
        if (pa || pb) begin
          res_hit           = 1'b1;
          res.kind          = stc_pkg::KIND_SAMPLE;
          res.capture_index = cap_pos_wide[stc_pkg::INDEX_W-1:0];
          res.captured_a    = pa ? sample_a : '0;
          res.captured_b    = pb ? sample_b : '0;
          res.a_present     = pa;
          res.b_present     = pb;
          res.last          = cap_pos == stc_pkg::LAST_POS;
        end
        if (cap_pos == stc_pkg::LAST_POS) begin
          // end of frame: drop one wake from idle channels
          if (!a_streaming && pa) wake_a_next = wake_a - stc_pkg::WAKE_W'(1);
          if (!b_streaming && pb) wake_b_next = wake_b - stc_pkg::WAKE_W'(1);
          if (wake_a_next == '0 && wake_b_next == '0 && !trigger_streaming) begin
            mode_next = MODE_SLEEP;
          end else begin
            cnt_next  = $signed({1'b0, holdoff_samples});
            mode_next = MODE_HOLDOFF;
          end
          pos_next = '0;
        end else begin
          pos_next = cap_pos + stc_pkg::POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_timeout <= stc_pkg::TIMEOUT_RESET;
      holdoff_samples <= stc_pkg::HOLDOFF_RESET;
      polyphonic      <= 1'b0;
      mode            <= MODE_CAPTURING;
      pos             <= '0;
      cnt             <= '0;
      wake_a          <= '0;
      wake_b          <= '0;
      result_valid    <= 1'b0;
      skid_valid      <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          stc_pkg::REG_TRIGGER_TIMEOUT: trigger_timeout <= cfg_data;
          stc_pkg::REG_HOLDOFF_SAMPLES: holdoff_samples <= cfg_data;
          stc_pkg::REG_POLYPHONIC:      polyphonic      <= cfg_data[0];
          default: begin
          end
        endcase
      end
      mode   <= mode_next;
      pos    <= pos_next;
      cnt    <= cnt_next;
      wake_a <= wake_a_next;
      wake_b <= wake_b_next;

      if (result_take || !result_valid) begin
        // advance: skid entry first, then the new item
        result_valid <= skid_valid || res_hit;
        out_r        <= skid_valid ? skid_r : res;
        skid_valid   <= skid_valid && res_hit;
        if (skid_valid) skid_r <= res;
      end else if (res_hit) begin
        // hold the result, park the new item
        skid_valid <= 1'b1;
        skid_r     <= res;
      end
    end
  end

  assign kind          = out_r.kind;
  assign capture_index = out_r.capture_index;
  assign captured_a    = out_r.captured_a;
  assign captured_b    = out_r.captured_b;
  assign a_present     = out_r.a_present;
  assign b_present     = out_r.b_present;
  assign last          = out_r.last;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid entry held with empty result register");

  a_sleep_tick_quiet: assert property (@(posedge clk) disable iff (rst)
    (item_accept && command == stc_pkg::CMD_TICK && mode == MODE_SLEEP)
      |-> (!res_hit && mode_next == MODE_SLEEP))
    else $error("sample tick acted while asleep");

  a_pos_in_frame: assert property (@(posedge clk) disable iff (rst)
    pos <= stc_pkg::LAST_POS)
    else $error("capture position beyond frame");

  a_blank_zero: assert property (@(posedge clk) disable iff (rst)
    (res_hit && res.kind == stc_pkg::KIND_BLANK)
      |-> (res.capture_index == '0 && !res.a_present && !res.b_present && !res.last
           && res.captured_a == '0 && res.captured_b == '0))
    else $error("blank marker carries data");

endmodule

// ----- dv/scope_trigger_capture_tb.sv -----
// Self-checking testbench for the scope trigger capture sequencer.
module scope_trigger_capture_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [stc_pkg::CFG_IDX_W-1:0] REG_UNUSED = stc_pkg::CFG_IDX_W'(3);
  localparam int IDLE_PCT = 38;
  localparam int STUCK_LIMIT = 300;

  typedef enum logic [2:0] {
    SEQ_CAPTURE, SEQ_ARM, SEQ_FIRE, SEQ_HOLDOFF, SEQ_SLEEP
  } seq_mode_t;

  typedef struct {
    logic                                command;
    logic signed [stc_pkg::SAMPLE_W-1:0] sample_a;
    logic signed [stc_pkg::SAMPLE_W-1:0] sample_b;
    logic signed [stc_pkg::SAMPLE_W-1:0] trigger_sample;
    logic                                a_streaming;
    logic                                b_streaming;
    logic                                trigger_streaming;
    logic                                a_updated;
    logic                                b_updated;
    logic                                voice_updated;
    logic                                voice_active;
  } item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                                item_valid = 1'b0;
  logic                                item_stall;
  logic                                command = stc_pkg::CMD_TICK;
  logic signed [stc_pkg::SAMPLE_W-1:0] sample_a = '0;
  logic signed [stc_pkg::SAMPLE_W-1:0] sample_b = '0;
  logic signed [stc_pkg::SAMPLE_W-1:0] trigger_sample = '0;
  logic                                a_streaming = 1'b0;
  logic                                b_streaming = 1'b0;
  logic                                trigger_streaming = 1'b0;
  logic                                a_updated = 1'b0;
  logic                                b_updated = 1'b0;
  logic                                voice_updated = 1'b0;
  logic                                voice_active = 1'b0;

  logic                                result_valid;
  logic                                result_stall = 1'b0;
  logic                                kind;
  logic [stc_pkg::INDEX_W-1:0]         capture_index;
  logic signed [stc_pkg::SAMPLE_W-1:0] captured_a;
  logic signed [stc_pkg::SAMPLE_W-1:0] captured_b;
  logic                                a_present;
  logic                                b_present;
  logic                                last;

  logic                          cfg_write = 1'b0;
  logic [stc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [stc_pkg::REG_W-1:0]     cfg_data = '0;

  // Sequencer prediction state.
  seq_mode_t                  seq_mode = SEQ_CAPTURE;
  int unsigned                cap_pos = 0;
  int                         countdown = 0;
  logic [stc_pkg::WAKE_W-1:0] wake_a = '0;
  logic [stc_pkg::WAKE_W-1:0] wake_b = '0;
  logic [stc_pkg::REG_W-1:0]  timeout_reg = stc_pkg::TIMEOUT_RESET;
  logic [stc_pkg::REG_W-1:0]  holdoff_reg = stc_pkg::HOLDOFF_RESET;
  logic                       poly_reg = 1'b0;

  stc_pkg::result_t captures_due[$];

  bit no_idle = 1'b0;
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int frames_done = 0;
  int blanks_due = 0;

  scope_trigger_capture uut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) result_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);

  // ---------------------------------------------------------------- predictor

  function automatic void take_sample(input item_t it);
    stc_pkg::result_t r;
    logic pa, pb, fin;
    int unsigned p;
    pa = (wake_a != 0);
    pb = (wake_b != 0);
    p = cap_pos;
    cap_pos = p + 1;
    fin = (cap_pos >= stc_pkg::CAPTURE_LENGTH);
    if (pa || pb) begin
      r.kind = stc_pkg::KIND_SAMPLE;
      r.capture_index = p[stc_pkg::INDEX_W-1:0];
      r.captured_a = pa ? it.sample_a : '0;
      r.captured_b = pb ? it.sample_b : '0;
      r.a_present = pa;
      r.b_present = pb;
      r.last = fin;
      captures_due.push_back(r);
    end
    if (fin) begin
      // wake counts saturate at zero
      if (!it.a_streaming && wake_a != 0) wake_a = wake_a - 1'b1;
      if (!it.b_streaming && wake_b != 0) wake_b = wake_b - 1'b1;
      if (wake_a == 0 && wake_b == 0 && !it.trigger_streaming) begin
        seq_mode = SEQ_SLEEP;
      end else begin
        countdown = int'(holdoff_reg);
        seq_mode = SEQ_HOLDOFF;
      end
      cap_pos = 0;
      frames_done++;
    end
  endfunction

  function automatic void advance_sequencer(input item_t it);
    stc_pkg::result_t r;
    if (it.command == stc_pkg::CMD_UPDATE) begin
      if (it.a_updated) wake_a = stc_pkg::WAKE_FULL;
      if (it.b_updated) wake_b = stc_pkg::WAKE_FULL;
      if (seq_mode == SEQ_SLEEP) seq_mode = SEQ_CAPTURE;
      // mute is checked after the wake-up, so it wins
      if (it.voice_updated && !it.voice_active && poly_reg) begin
        r = '0;
        r.kind = stc_pkg::KIND_BLANK;
        captures_due.push_back(r);
        seq_mode = SEQ_SLEEP;
        blanks_due++;
      end
      return;
    end
    case (seq_mode)
      SEQ_CAPTURE: take_sample(it);
      SEQ_ARM: begin
        countdown = countdown - 1;
        if (it.trigger_sample <= 0) begin
          cap_pos = 0;
          seq_mode = (countdown < 0) ? SEQ_CAPTURE : SEQ_FIRE;
        end else if (countdown < 0) begin
          seq_mode = SEQ_FIRE;
        end
      end
      SEQ_FIRE: begin
        if (it.trigger_sample > 0) begin
          cap_pos = 0;
          seq_mode = SEQ_CAPTURE;
          take_sample(it);
        end else begin
          countdown = countdown - 1;
          if (countdown < 0) begin
            cap_pos = 0;
            seq_mode = SEQ_CAPTURE;
          end
        end
      end
      SEQ_HOLDOFF: begin
        countdown = countdown - 1;
        if (countdown < 0) begin
          countdown = int'(timeout_reg);
          seq_mode = SEQ_ARM;
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : result_monitor
    stc_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (captures_due.size() == 0) begin
        $display("%0t: unexpected result, expected none got index %h", $time,
                 capture_index);
        errors++;
      end else begin
        want = captures_due.pop_front();
        results_seen++;
        check_field("kind", 16'(want.kind), 16'(kind));
        check_field("capture_index", 16'(want.capture_index), 16'(capture_index));
        check_field("captured_a", want.captured_a, captured_a);
        check_field("captured_b", want.captured_b, captured_b);
        check_field("a_present", 16'(want.a_present), 16'(a_present));
        check_field("b_present", 16'(want.b_present), 16'(b_present));
        check_field("last", 16'(want.last), 16'(last));
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic logic signed [stc_pkg::SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return '0;
      3: return '1;
      default: return stc_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  // Trigger values split roughly evenly around zero to arm and fire often.
  function automatic logic signed [stc_pkg::SAMPLE_W-1:0] trig_sample();
    case ($urandom_range(9))
      0: return '0;
      1: return 16'sh8000;
      2: return 16'sh7FFF;
      3, 4, 5: return stc_pkg::SAMPLE_W'($urandom_range(32767, 1));
      default: return stc_pkg::SAMPLE_W'(-int'($urandom_range(32768, 1)));
    endcase
  endfunction

  function automatic item_t random_item();
    item_t it;
    it.command = stc_pkg::CMD_TICK;
    it.sample_a = rand_sample();
    it.sample_b = rand_sample();
    it.trigger_sample = rand_sample();
    it.a_streaming = 1'($urandom_range(1));
    it.b_streaming = 1'($urandom_range(1));
    it.trigger_streaming = 1'($urandom_range(1));
    it.a_updated = 1'($urandom_range(1));
    it.b_updated = 1'($urandom_range(1));
    it.voice_updated = ($urandom_range(99) < 30);
    it.voice_active = 1'($urandom_range(1));
    return it;
  endfunction

  function automatic item_t make_item(input int upd_pm, input int stream_pct);
    item_t it;
    it = random_item();
    it.a_streaming = ($urandom_range(99) < stream_pct);
    it.b_streaming = ($urandom_range(99) < stream_pct);
    it.trigger_streaming = ($urandom_range(99) < stream_pct);
    if (seq_mode == SEQ_SLEEP) begin
      // wake up soon; ticks while asleep are dropped
      if ($urandom_range(99) < 70) it.command = stc_pkg::CMD_UPDATE;
    end else if ($urandom_range(999) < upd_pm) begin
      it.command = stc_pkg::CMD_UPDATE;
    end else if (seq_mode != SEQ_CAPTURE) begin
      it.trigger_sample = trig_sample();
    end
    return it;
  endfunction

  task automatic send_item(input item_t it);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    command <= it.command;
    sample_a <= it.sample_a;
    sample_b <= it.sample_b;
    trigger_sample <= it.trigger_sample;
    a_streaming <= it.a_streaming;
    b_streaming <= it.b_streaming;
    trigger_streaming <= it.trigger_streaming;
    a_updated <= it.a_updated;
    b_updated <= it.b_updated;
    voice_updated <= it.voice_updated;
    voice_active <= it.voice_active;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    advance_sequencer(it);
    items_sent++;
  endtask

  task automatic tick(input logic signed [stc_pkg::SAMPLE_W-1:0] sa,
                      input logic signed [stc_pkg::SAMPLE_W-1:0] sb,
                      input logic signed [stc_pkg::SAMPLE_W-1:0] st,
                      input logic [2:0] streams);
    item_t it;
    it = random_item();
    it.command = stc_pkg::CMD_TICK;
    it.sample_a = sa;
    it.sample_b = sb;
    it.trigger_sample = st;
    {it.a_streaming, it.b_streaming, it.trigger_streaming} = streams;
    send_item(it);
  endtask

  task automatic update(input logic a_upd, input logic b_upd, input logic v_upd,
                        input logic v_act);
    item_t it;
    it = random_item();
    it.command = stc_pkg::CMD_UPDATE;
    it.a_updated = a_upd;
    it.b_updated = b_upd;
    it.voice_updated = v_upd;
    it.voice_active = v_act;
    send_item(it);
  endtask

  // Hold off until every expected result is out and the pipeline has settled.
  task automatic drain();
    item_valid <= 1'b0;
    while (captures_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [stc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [stc_pkg::REG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    case (idx)
      stc_pkg::REG_TRIGGER_TIMEOUT: timeout_reg = data;
      stc_pkg::REG_HOLDOFF_SAMPLES: holdoff_reg = data;
      stc_pkg::REG_POLYPHONIC: poly_reg = data[0];
      default: ;
    endcase
  endtask

  // Run random items until a frame has ended and the sequencer reaches the
  // requested stopping point, or until the item budget is spent. A polyphonic
  // setup escapes a long wait by muting.
  task automatic run_phase(input logic [stc_pkg::REG_W-1:0] tmo,
                           input logic [stc_pkg::REG_W-1:0] hold,
                           input logic poly, input int upd_pm, input int stream_pct,
                           input bit stop_in_holdoff, input int max_items);
    int start_frames;
    int stuck;
    int sent;
    item_t it;
    drain();
    write_reg(stc_pkg::REG_TRIGGER_TIMEOUT, tmo);
    write_reg(stc_pkg::REG_HOLDOFF_SAMPLES, hold);
    write_reg(stc_pkg::REG_POLYPHONIC, {(stc_pkg::REG_W-1)'($urandom), poly});
    start_frames = frames_done;
    stuck = 0;
    sent = 0;
    while (sent < max_items && (frames_done == start_frames ||
           !(seq_mode == SEQ_CAPTURE || (stop_in_holdoff && seq_mode == SEQ_HOLDOFF)))) begin
      if (seq_mode != SEQ_CAPTURE && seq_mode != SEQ_SLEEP) stuck++;
      else stuck = 0;
      it = make_item(upd_pm, stream_pct);
      if (stuck > STUCK_LIMIT && poly_reg) begin
        it.command = stc_pkg::CMD_UPDATE;
        it.voice_updated = 1'b1;
        it.voice_active = 1'b0;
      end
      send_item(it);
      sent++;
    end
  endtask

  // ---------------------------------------------------------------- tests

  // From reset no channel is awake: ticks advance the frame position and
  // produce no results.
  task automatic test_silent_frame();
    item_t it;
    for (int i = 0; i < 200; i++) begin
      it = random_item();
      it.command = stc_pkg::CMD_TICK;
      send_item(it);
    end
  endtask

  task automatic test_directed_capture();
    update(1'b1, 1'b0, 1'b1, 1'b0);
    tick(16'sh7FFF, 16'sh8000, '0, 3'b000);
    update(1'b0, 1'b1, 1'b0, 1'b0);
    tick(16'sh8000, 16'sh7FFF, 16'sh8000, 3'b111);
    tick('0, '0, 16'sh7FFF, 3'b000);
    tick('1, 16'sh0001, 16'sh0001, 3'b101);
    tick(16'sh5555, 16'shAAAA, 16'shAAAA, 3'b010);
    tick(16'shAAAA, 16'sh5555, 16'sh5555, 3'b000);
    drain();
    write_reg(stc_pkg::REG_POLYPHONIC, '1);
    write_reg(REG_UNUSED, '1);
    update(1'b0, 1'b0, 1'b1, 1'b1);
    tick(rand_sample(), rand_sample(), rand_sample(), 3'b000);
    update(1'b1, 1'b0, 1'b1, 1'b0);
    tick(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 3'b111);
    tick(16'sh8000, 16'sh8000, 16'sh8000, 3'b000);
    // wake with no channel flagged: resume at the kept position
    update(1'b0, 1'b0, 1'b0, 1'b0);
    tick(rand_sample(), rand_sample(), rand_sample(), 3'b000);
    tick(rand_sample(), rand_sample(), rand_sample(), 3'b000);
    drain();
    write_reg(stc_pkg::REG_POLYPHONIC, {{(stc_pkg::REG_W-1){1'b1}}, 1'b0});
    update(1'b0, 1'b0, 1'b1, 1'b0);
    tick(rand_sample(), rand_sample(), rand_sample(), 3'b000);
  endtask

  // Finish the frame and stop in capture or holdoff; from holdoff the next phase re-arms.
  task automatic test_short_delays();
    run_phase(stc_pkg::REG_W'($urandom_range(40, 1)), stc_pkg::REG_W'($urandom_range(40, 1)),
              1'b1, 15, 5, 1'b1, 1000);
  endtask

  task automatic test_zero_delays();
    no_idle = 1'b1;
    run_phase('0, '0, 1'b0, 10, 20, 1'b0, 120);
    no_idle = 1'b0;
  endtask

  task automatic test_max_delays();
    run_phase('1, '1, 1'b1, 5, 40, 1'b0, 60);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_silent_frame();
    test_directed_capture();
    test_short_delays();
    test_zero_delays();
    test_max_delays();
    drain();
    $display("sent %0d items, checked %0d results over %0d frames, %0d voice blanks",
             items_sent, results_seen, frames_done, blanks_due);
    $display("silent ticks, wake and mute updates, a full frame, then re-arm and capture");
    if (errors == 0) begin
      $display("scope_trigger_capture: match");
    end else begin
      $display("scope_trigger_capture: mismatch");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("%0t: run timed out", $time);
    $display("scope_trigger_capture: mismatch");
    $finish;
  end

endmodule
